// File: rtl/srt_pkg.sv
// Package with command, status and payload types for the sorted record table.
package srt_pkg;

	localparam int KEY_W   = 34;
	localparam int SCORE_W = 7;
	localparam int PACK_W  = 5 * SCORE_W;
	localparam int LIST_MAX = 16;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_LB_RD,
		S_LB_CMP,
		S_CHK_RD,
		S_CHK_CMP,
		S_RM_RD,
		S_RM_WR,
		S_LST_RD,
		S_LST_OUT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   new_key;
		logic [SCORE_W-1:0] score_a;
		logic [SCORE_W-1:0] score_b;
		logic [SCORE_W-1:0] score_c;
		logic [SCORE_W-1:0] score_d;
		logic [SCORE_W-1:0] score_e;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         position;
		logic [KEY_W-1:0]   found_key;
		logic [SCORE_W-1:0] out_a;
		logic [SCORE_W-1:0] out_b;
		logic [SCORE_W-1:0] out_c;
		logic [SCORE_W-1:0] out_d;
		logic [SCORE_W-1:0] out_e;
		logic               last;
	} rsp_t;

	function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] v);
		clamp_score = (v > SCORE_MAX) ? SCORE_MAX : v;
	endfunction

endpackage

// File: rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sorted_record_table_top.sv
// Top level of the sorted record table: sequencer around key and score RAMs.
//
// Usage: one request channel (req_valid/req_ready/req) carries commands:
// insert, lookup, update and list. One response channel (rsp_valid/
// rsp_ready/rsp) returns results; every command gives one result except
// list, which gives one result per stored record (at most sixteen, or one
// not-found result when empty), the final one marked by last. Records sit
// in two RAMs in ascending key order. Steps, built on the registered read:
//   lookup: binary search for the lower bound, then a read to check the key.
//   insert: each record with a larger key moves up one slot, top down,
//           then the new record is written into the freed slot.
//   update: lookup, then each record after the hit moves down, then insert.
//   list: one read per record.
// One command is in work at a time; req_ready is high only when idle. The
// response register holds its transaction while rsp_ready is low, and the
// sequencer waits for it before loading the next result.
// Reset empties the table (entry count zero); the RAM contents are not
// cleared since only entries below the count are read.
module sorted_record_table_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  srt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output srt_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	srt_pkg::state_t state_q, state_d;

	logic [1:0]                   cmd_q;
	logic [srt_pkg::KEY_W-1:0]    key_q;
	logic [srt_pkg::KEY_W-1:0]    nkey_q;
	logic [srt_pkg::PACK_W-1:0]   packed_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                i_q;
	logic [CW-1:0]                lo_q;
	logic [CW-1:0]                hi_q;
	logic [CW-1:0]                mid_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                j_q;
	srt_pkg::rsp_t                res_q;
	srt_pkg::rsp_t                out_q;
	logic                         out_valid_q;

	logic [srt_pkg::KEY_W-1:0]    k_sel;
	logic [CW-1:0]                mid;
	logic [CW:0]                  idx_nx;
	logic                         slot_free;
	logic                         full;
	logic                         list_last;
	logic                         ram_we;
	logic [AW-1:0]                waddr;
	logic [AW-1:0]                raddr;
	logic [srt_pkg::KEY_W-1:0]    wkey;
	logic [srt_pkg::PACK_W-1:0]   wscore;
	logic [srt_pkg::KEY_W-1:0]    rd_key;
	logic [srt_pkg::PACK_W-1:0]   rd_score;
	logic                         accept;

	srt_ram #(.WIDTH(srt_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wkey),
		.raddr(raddr), .rdata(rd_key)
	);

	srt_ram #(.WIDTH(srt_pkg::PACK_W), .DEPTH(CAPACITY)) u_score_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wscore),
		.raddr(raddr), .rdata(rd_score)
	);

	// Shared decode
	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == srt_pkg::S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign slot_free = !out_valid_q || rsp_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign k_sel     = (cmd_q == srt_pkg::CMD_UPDATE) ? nkey_q : key_q;
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_nx    = {1'b0, idx_q} + (CW + 1)'(1);
	assign list_last = (({1'b0, j_q} + (CW + 1)'(1)) == {1'b0, count_q}) ||
		(32'(j_q) == 32'(srt_pkg::LIST_MAX - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srt_pkg::S_IDLE: begin
				if (accept) begin
					case (req.cmd)
						srt_pkg::CMD_INSERT: state_d = full ? srt_pkg::S_EMIT : srt_pkg::S_INS_RD;
						srt_pkg::CMD_LIST:   state_d = (count_q == '0) ? srt_pkg::S_EMIT
							: srt_pkg::S_LST_RD;
						default:             state_d = srt_pkg::S_LB_RD;
					endcase
				end
			end
			srt_pkg::S_INS_RD:  state_d = (i_q == '0) ? srt_pkg::S_EMIT : srt_pkg::S_INS_CMP;
			srt_pkg::S_INS_CMP: state_d = (rd_key > k_sel) ? srt_pkg::S_INS_RD : srt_pkg::S_EMIT;
			srt_pkg::S_LB_RD:   state_d = (lo_q < hi_q) ? srt_pkg::S_LB_CMP : srt_pkg::S_CHK_RD;
			srt_pkg::S_LB_CMP:  state_d = srt_pkg::S_LB_RD;
			srt_pkg::S_CHK_RD:  state_d = (lo_q >= count_q) ? srt_pkg::S_EMIT : srt_pkg::S_CHK_CMP;
			srt_pkg::S_CHK_CMP: begin
				if (rd_key != key_q || cmd_q == srt_pkg::CMD_LOOKUP) begin
					state_d = srt_pkg::S_EMIT;
				end else begin
					state_d = srt_pkg::S_RM_RD;
				end
			end
			srt_pkg::S_RM_RD:   state_d = (idx_nx < {1'b0, count_q}) ? srt_pkg::S_RM_WR
				: srt_pkg::S_INS_RD;
			srt_pkg::S_RM_WR:   state_d = srt_pkg::S_RM_RD;
			srt_pkg::S_LST_RD:  state_d = srt_pkg::S_LST_OUT;
			srt_pkg::S_LST_OUT: begin
				if (slot_free) begin
					state_d = list_last ? srt_pkg::S_IDLE : srt_pkg::S_LST_RD;
				end
			end
			srt_pkg::S_EMIT:    state_d = slot_free ? srt_pkg::S_IDLE : srt_pkg::S_EMIT;
			default:            state_d = srt_pkg::S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we = 1'b0;
		waddr  = i_q[AW-1:0];
		wkey   = k_sel;
		wscore = packed_q;
		raddr  = '0;
		case (state_q)
			srt_pkg::S_INS_RD: begin
				if (i_q == '0) begin
					ram_we = 1'b1;
				end
				raddr = AW'(i_q - CW'(1));
			end
			srt_pkg::S_INS_CMP: begin
				ram_we = 1'b1;
				if (rd_key > k_sel) begin
					wkey   = rd_key;
					wscore = rd_score;
				end
			end
			srt_pkg::S_LB_RD:  raddr = mid[AW-1:0];
			srt_pkg::S_CHK_RD: raddr = lo_q[AW-1:0];
			srt_pkg::S_RM_RD:  raddr = idx_nx[AW-1:0];
			srt_pkg::S_RM_WR: begin
				ram_we = 1'b1;
				waddr  = idx_q[AW-1:0];
				wkey   = rd_key;
				wscore = rd_score;
			end
			srt_pkg::S_LST_RD:  raddr = j_q[AW-1:0];
			srt_pkg::S_LST_OUT: raddr = j_q[AW-1:0];
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srt_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == srt_pkg::S_EMIT || state_q == srt_pkg::S_LST_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == srt_pkg::S_INS_RD && i_q == '0) ||
				(state_q == srt_pkg::S_INS_CMP && !(rd_key > k_sel))) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == srt_pkg::S_RM_RD && !(idx_nx < {1'b0, count_q})) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			key_q    <= req.key;
			nkey_q   <= req.new_key;
			packed_q <= {srt_pkg::clamp_score(req.score_e), srt_pkg::clamp_score(req.score_d),
				srt_pkg::clamp_score(req.score_c), srt_pkg::clamp_score(req.score_b),
				srt_pkg::clamp_score(req.score_a)};
			i_q      <= count_q;
			lo_q     <= '0;
			hi_q     <= count_q;
			j_q      <= '0;
			res_q    <= '{
				status: (req.cmd == srt_pkg::CMD_INSERT && full) ? srt_pkg::ST_FULL
					: (req.cmd == srt_pkg::CMD_LIST) ? srt_pkg::ST_NOTFOUND : srt_pkg::ST_OK,
				position: '0, found_key: '0, out_a: '0, out_b: '0, out_c: '0,
				out_d: '0, out_e: '0, last: 1'b1};
		end
		case (state_q)
			srt_pkg::S_INS_RD: begin
				if (i_q == '0) begin
					res_q <= {srt_pkg::ST_OK, 4'd0, k_sel, packed_q[6:0], packed_q[13:7],
						packed_q[20:14], packed_q[27:21], packed_q[34:28], 1'b1};
				end
			end
			srt_pkg::S_INS_CMP: begin
				if (rd_key > k_sel) begin
					i_q <= i_q - CW'(1);
				end else begin
					res_q <= {srt_pkg::ST_OK, 4'(i_q), k_sel, packed_q[6:0], packed_q[13:7],
						packed_q[20:14], packed_q[27:21], packed_q[34:28], 1'b1};
				end
			end
			srt_pkg::S_LB_RD:  mid_q <= mid;
			srt_pkg::S_LB_CMP: begin
				if (rd_key < key_q) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			srt_pkg::S_CHK_RD: begin
				res_q.status <= srt_pkg::ST_NOTFOUND;
			end
			srt_pkg::S_CHK_CMP: begin
				idx_q <= lo_q;
				if (rd_key == key_q && cmd_q == srt_pkg::CMD_LOOKUP) begin
					res_q <= {srt_pkg::ST_OK, 4'(lo_q), rd_key, rd_score[6:0], rd_score[13:7],
						rd_score[20:14], rd_score[27:21], rd_score[34:28], 1'b1};
				end
			end
			srt_pkg::S_RM_RD: begin
				if (!(idx_nx < {1'b0, count_q})) begin
					i_q <= count_q - CW'(1);
				end
			end
			srt_pkg::S_RM_WR: idx_q <= idx_nx[CW-1:0];
			srt_pkg::S_LST_OUT: begin
				if (slot_free) begin
					out_q <= {srt_pkg::ST_OK, 4'(j_q), rd_key, rd_score[6:0], rd_score[13:7],
						rd_score[20:14], rd_score[27:21], rd_score[34:28], list_last};
					j_q   <= j_q + CW'(1);
				end
			end
			srt_pkg::S_EMIT: begin
				if (slot_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srt_pkg::S_EMIT && slot_free && res_q.status == srt_pkg::ST_FULL)
		|-> full)
		else $error("full status with room in the table");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != srt_pkg::S_IDLE) |-> !req_ready)
		else $error("request taken while a command is in work");
`endif

endmodule
